[sv/assert_macros.svh]
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

[sv/vr_pkg.sv]
// ---------------------------------------------------------------------------
// vr_pkg
// Types and constants of the vector refraction pipeline.
// ---------------------------------------------------------------------------
package vr_pkg;
   localparam int CompW = 20;
   localparam int EtaW  = 19;

   typedef logic signed [CompW-1:0] comp_type;

   typedef struct packed {
      comp_type             dir_x;
      comp_type             dir_y;
      comp_type             dir_z;
      comp_type             norm_x;
      comp_type             norm_y;
      comp_type             norm_z;
      logic     [EtaW-1:0]  eta;
   } req_type;

   typedef struct packed {
      comp_type out_x;
      comp_type out_y;
      comp_type out_z;
   } rsp_type;

   localparam logic signed [63:0] QOne32 = 64'sh1_0000_0000;
   localparam logic signed [19:0] OutMax = 20'sh7FFFF;
   localparam logic signed [19:0] OutMin = -20'sh80000;
endpackage

[sv/vr_req_if.sv]
// ---------------------------------------------------------------------------
// vr_req_if
// Valid/ready channel carrying one refraction request.
// ---------------------------------------------------------------------------
interface vr_req_if;
   logic            valid;
   logic            ready;
   vr_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/vr_rsp_if.sv]
// ---------------------------------------------------------------------------
// vr_rsp_if
// Valid/ready channel carrying one refracted direction.
// ---------------------------------------------------------------------------
interface vr_rsp_if;
   logic            valid;
   logic            ready;
   vr_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/vr_isqrt.sv]
// ---------------------------------------------------------------------------
// vr_isqrt
// Pipelined floor square root of a 64-bit value, two result bits per stage,
// carrying a side payload along.
// ---------------------------------------------------------------------------
module vr_isqrt #(
   parameter int SideW = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [63:0]      in_value,
   input  logic [SideW-1:0] in_side,
   output logic             out_valid,
   output logic [31:0]      out_root,
   output logic [SideW-1:0] out_side
);
   localparam int Stages = 16;
   localparam int BitsPer = 2;

   // element s holds the state after stage s
   logic [Stages-1:0]     v_ff;
   logic [63:0]           x_ff    [Stages];
   logic [31:0]           r_ff    [Stages];
   logic [SideW-1:0]      side_ff [Stages];
   logic [63:0]           x_src   [Stages];
   logic [31:0]           r_src   [Stages];
   logic [63:0]           x_in    [Stages];
   logic [31:0]           r_in    [Stages];

   // Each stage resolves BitsPer root bits, most significant first.
   always_comb begin
      logic [63:0] x;
      logic [31:0] r;
      logic [63:0] trial;
      int          j;
      x_src[0] = in_value;
      r_src[0] = '0;
      for (int s = 1; s < Stages; s++) begin
         x_src[s] = x_ff[s-1];
         r_src[s] = r_ff[s-1];
      end
      for (int s = 0; s < Stages; s++) begin
         x = x_src[s];
         r = r_src[s];
         for (int k = 0; k < BitsPer; k++) begin
            j = 31 - (s * BitsPer + k);
            // (r + 2^j)^2 - r^2, with r holding only bits above j
            trial = ({32'd0, r} << (j + 1)) | (64'd1 << (2 * j));
            if (x >= trial) begin
               x = x - trial;
               r = r | (32'd1 << j);
            end
         end
         x_in[s] = x;
         r_in[s] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[Stages-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= in_side;
         for (int s = 1; s < Stages; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 0; s < Stages; s++) begin
            x_ff[s] <= x_in[s];
            r_ff[s] <= r_in[s];
         end
      end
   end

   assign out_valid = v_ff[Stages-1];
   assign out_root  = r_ff[Stages-1];
   assign out_side  = side_ff[Stages-1];
endmodule

[sv/vector_refraction.sv]
// Structure: 8 arithmetic stages, then a 16-stage square root (two root
// bits per stage), then the registered output.
// Throughput: one request per cycle; the whole pipeline stalls as one when
// the result is held, and a full output register takes a request only while rsp.ready is high.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
// vector_refraction
// Snell's law refraction of a direction about a normal in Q4.16 fixed point.
// ---------------------------------------------------------------------------
module vector_refraction (
   input  logic         clock,
   input  logic         reset,
   vr_req_if.sink       req,
   vr_rsp_if.source     rsp
);
   localparam int SideW = 3 * (20 + 32);

   logic advance;
   assign advance = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // stage 1: input register
   logic v1_ff;
   vr_pkg::req_type r1_ff;
   // stage 2: three products of the dot product
   logic v2_ff;
   vr_pkg::req_type r2_ff;
   logic signed [39:0] p2_ff [3];
   // stage 3: clamped, rounded cosine
   logic v3_ff;
   vr_pkg::req_type r3_ff;
   logic signed [42:0] c3_ff;
   // stage 4: c*n products
   logic v4_ff;
   vr_pkg::req_type r4_ff;
   logic signed [63:0] cn4_ff [3];
   // stage 5: rounded d + c*n
   logic v5_ff;
   logic [18:0] eta5_ff;
   vr_pkg::comp_type n5_ff [3];
   logic signed [47:0] s5_ff [3];
   // stage 6: perp, truncated to 32 bits signed
   logic v6_ff;
   vr_pkg::comp_type n6_ff [3];
   logic signed [31:0] pp6_ff [3];
   // stage 7: perp squared
   logic v7_ff;
   vr_pkg::comp_type n7_ff [3];
   logic signed [31:0] pp7_ff [3];
   logic [63:0] sq7_ff [3];
   // stage 8: |1 - perp.perp|
   logic v8_ff;
   vr_pkg::comp_type n8_ff [3];
   logic signed [31:0] pp8_ff [3];
   logic [63:0] diff8_ff;
   logic        big8_ff;

   // rounding helper: floor((v + 2^15) / 2^16)
   function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
      logic signed [63:0] t;
      t = v + 64'sd32768;
      return t >>> 16;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         {v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff} <= '0;
      end else if (advance) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [63:0] dot;
      logic signed [63:0] c;
      logic signed [63:0] s;
      logic signed [111:0] lsq;
      logic signed [111:0] df;
      if (advance) begin
         r1_ff <= req.data;

         r2_ff    <= r1_ff;
         p2_ff[0] <= r1_ff.dir_x * r1_ff.norm_x;
         p2_ff[1] <= r1_ff.dir_y * r1_ff.norm_y;
         p2_ff[2] <= r1_ff.dir_z * r1_ff.norm_z;

         r3_ff <= r2_ff;
         dot = 64'(p2_ff[0]) + 64'(p2_ff[1]) + 64'(p2_ff[2]);
         c = -dot;
         if (c > vr_pkg::QOne32) begin
            c = vr_pkg::QOne32;
         end
         c3_ff <= 43'(rnd16(c));

         r4_ff     <= r3_ff;
         cn4_ff[0] <= 64'(c3_ff * r3_ff.norm_x);
         cn4_ff[1] <= 64'(c3_ff * r3_ff.norm_y);
         cn4_ff[2] <= 64'(c3_ff * r3_ff.norm_z);

         eta5_ff  <= r4_ff.eta;
         n5_ff[0] <= r4_ff.norm_x;
         n5_ff[1] <= r4_ff.norm_y;
         n5_ff[2] <= r4_ff.norm_z;
         s = (64'(r4_ff.dir_x) <<< 16) + cn4_ff[0];
         s5_ff[0] <= 48'(rnd16(s));
         s = (64'(r4_ff.dir_y) <<< 16) + cn4_ff[1];
         s5_ff[1] <= 48'(rnd16(s));
         s = (64'(r4_ff.dir_z) <<< 16) + cn4_ff[2];
         s5_ff[2] <= 48'(rnd16(s));

         for (int i = 0; i < 3; i++) begin
            n6_ff[i]  <= n5_ff[i];
            pp6_ff[i] <= 32'(rnd16(64'(s5_ff[i] * $signed({1'b0, eta5_ff}))));
            n7_ff[i]  <= n6_ff[i];
            pp7_ff[i] <= pp6_ff[i];
            sq7_ff[i] <= 64'(pp6_ff[i] * pp6_ff[i]);
            n8_ff[i]  <= n7_ff[i];
            pp8_ff[i] <= pp7_ff[i];
         end

         lsq = 112'(sq7_ff[0]) + 112'(sq7_ff[1]) + 112'(sq7_ff[2]);
         df = 112'(vr_pkg::QOne32) - lsq;
         if (df < 0) begin
            df = -df;
         end
         diff8_ff <= df[63:0];
         big8_ff  <= |df[111:64];
      end
   end

   // sqrt stage carries n (20 bits) and full-width perp (32 bits) per lane
   logic [SideW-1:0] side_in;
   logic [SideW-1:0] side_out;
   logic             sq_valid;
   logic [31:0]      sq_root;
   logic [63:0]      sq_arg;

   // roots of values past 2^64 never reach an unsaturated output; pin to max
   assign sq_arg = big8_ff ? '1 : diff8_ff;

   always_comb begin
      side_in = '0;
      for (int i = 0; i < 3; i++) begin
         side_in[i*52 +: 20]      = n8_ff[i];
         side_in[i*52 + 20 +: 32] = pp8_ff[i];
      end
   end

   vr_isqrt #(.SideW(SideW)) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v8_ff),
      .in_value  (sq_arg),
      .in_side   (side_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (side_out)
   );

   // final stage: perp*2^16 - root*n, round, saturate
   logic            rsp_valid_ff;
   vr_pkg::rsp_type rsp_data_ff;
   vr_pkg::comp_type res [3];

   always_comb begin
      logic signed [63:0] pv;
      logic signed [63:0] rn;
      logic signed [63:0] v;
      for (int i = 0; i < 3; i++) begin
         pv = 64'($signed(side_out[i*52 + 20 +: 32])) <<< 16;
         rn = 64'($signed({1'b0, sq_root}) * $signed(side_out[i*52 +: 20]));
         v  = rnd16(pv - rn);
         if (v > 64'(vr_pkg::OutMax)) begin
            res[i] = vr_pkg::OutMax;
         end else if (v < 64'(vr_pkg::OutMin)) begin
            res[i] = vr_pkg::OutMin;
         end else begin
            res[i] = v[19:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.out_x <= res[0];
         rsp_data_ff.out_y <= res[1];
         rsp_data_ff.out_z <= res[2];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;
endmodule

[sv/vr_checker.sv]
// ---------------------------------------------------------------------------
// vr_checker
// Port-level checks of the refraction pipeline handshake and flow.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vr_checker (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input vr_pkg::rsp_type rsp_data
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPL(a_ready_free, clock, reset, !rsp_valid, req_ready)
   `ASSERT_IMPL(a_stall_ready, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
endmodule

bind vector_refraction vr_checker u_vr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);
